// ----- src/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the tridiagonal solver: sizes, register
// indexes, operand selects and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int DIV_W     = DATA_W + FRAC_W;   // magnitude of dividend << 24
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SUB_DIAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_DIAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPER_DIAG = 2'd2;

  localparam logic [DATA_W-1:0] SUB_RST   = 32'hFF00_0000;  // -1.0
  localparam logic [DATA_W-1:0] MAIN_RST  = 32'h0200_0000;  //  2.0
  localparam logic [DATA_W-1:0] SUPER_RST = 32'hFF00_0000;  // -1.0

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MUL_AC,   // sub * super
    MUL_AG,   // sub * previous modified rhs
    MUL_CS    // super * solution of the row above
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_MUL,  // saturated product / pivot
    DIV_DIFF, // (rhs - product) / pivot
    DIV_G     // rhs / pivot
  } div_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRD,
    ST_FMUL1,
    ST_FSAT1,
    ST_FDIV1,
    ST_FWT1,
    ST_FMUL2,
    ST_FSAT2,
    ST_FDIV2,
    ST_FWT2,
    ST_FWR,
    ST_BRD,
    ST_BMUL,
    ST_BSAT,
    ST_BDIV,
    ST_BWT
  } state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_RD,
    OUT_LD,
    OUT_WT
  } out_ph_e;

  typedef struct packed {
    logic     in_take;
    logic     mem_rd;
    mul_sel_e mul_sel;
    logic     mul_take;
    logic     div_start;
    div_src_e div_src;
    logic     take_t1;
    logic     take_t2;
    logic     wr_fwd;
    logic     take_sol;
    logic     row_inc;
    logic     k_load_row;
    logic     k_dec;
    logic     k_inc;
    logic     k_clr;
    logic     sol_rd;
    logic     out_load;
    logic     run_clear;
  } tts_cmd_t;

  typedef struct packed {
    logic row_zero;
    logic row_full;
    logic last;
    logic k_zero;
    logic k_top;
    logic div_done;
    logic out_taken;
  } tts_stat_t;

endpackage

// ----- src/tts_div.sv -----
// ----------------------------------------------------------------------------
// tts_div
// Iterative signed Q8.24 divider, one quotient bit per cycle. Truncates
// toward zero, saturates to 32 bits and handles a zero divisor.
// ----------------------------------------------------------------------------
module tts_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tts_pkg::DATA_W-1:0] dividend_i,
  input  logic [tts_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [tts_pkg::DATA_W-1:0] quot_o,
  output logic                      flt_o
);
  import tts_pkg::*;

  logic [DIV_W-1:0]  work_q;    // dividend bits out, quotient bits in
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] dv_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              run_q;
  logic              done_q;
  logic              neg_q;
  logic              xneg_q;
  logic              zero_q;

  logic [DATA_W-1:0] x_mag;
  logic [DATA_W-1:0] y_mag;
  logic [DATA_W:0]   trial;
  logic              qbit;

  assign x_mag = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign y_mag = divisor_i[DATA_W-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign trial = {rem_q, work_q[DIV_W-1]} - {1'b0, dv_q};
  assign qbit  = ~trial[DATA_W];

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DCNT_W'(DIV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= {x_mag, {FRAC_W{1'b0}}};
      rem_q  <= '0;
      dv_q   <= y_mag;
      neg_q  <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      xneg_q <= dividend_i[DATA_W-1];
      zero_q <= (divisor_i == '0);
    end else if (run_q) begin
      rem_q  <= qbit ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], work_q[DIV_W-1]};
      work_q <= {work_q[DIV_W-2:0], qbit};
    end
  end

  // Sign and saturation of the finished quotient
  always_comb begin
    flt_o  = 1'b0;
    quot_o = work_q[DATA_W-1:0];
    if (zero_q) begin
      flt_o  = 1'b1;
      quot_o = xneg_q ? Q_MIN : Q_MAX;
    end else if (neg_q) begin
      if (work_q > DIV_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
        flt_o  = 1'b1;
        quot_o = Q_MIN;
      end else begin
        quot_o = ~work_q[DATA_W-1:0] + 1'b1;
      end
    end else if (work_q > DIV_W'(Q_MAX)) begin
      flt_o  = 1'b1;
      quot_o = Q_MAX;
    end
  end

  assign done_o = done_q;

endmodule

// ----- src/tts_datapath.sv -----
// ----------------------------------------------------------------------------
// tts_datapath
// Coefficient registers, row stores, shared multiplier and divider, fault
// tracking and the output register of the solver.
// ----------------------------------------------------------------------------
module tts_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tts_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic [tts_pkg::DATA_W-1:0]    in_data_i,
  input  logic                         in_last_i,
  input  tts_pkg::tts_cmd_t            cmd_i,
  output tts_pkg::tts_stat_t           stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [tts_pkg::DATA_W-1:0]    out_data_o,
  output logic                         out_last_o,
  output logic                         out_fault_o
);
  import tts_pkg::*;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t qsub(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
    logic [DATA_W:0] d;
    sat_t            r;
    d     = {x[DATA_W-1], x} - {y[DATA_W-1], y};
    r.ovf = d[DATA_W] ^ d[DATA_W-1];
    r.val = r.ovf ? (d[DATA_W] ? Q_MIN : Q_MAX) : d[DATA_W-1:0];
    return r;
  endfunction

  logic [DATA_W-1:0] sub_q, main_q, sup_q;
  logic [DATA_W-1:0] f_q;
  logic              last_q;
  logic [IDX_W-1:0]  row_q;
  logic [IDX_W-1:0]  k_q;
  logic              fault_q;
  logic [DATA_W-1:0] gp_q, dp_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] mul_q;
  logic [DATA_W-1:0] piv_new_q, rhs_new_q;
  logic [DATA_W-1:0] sol_q;
  logic [DATA_W:0]   sol_rd_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q;
  logic              out_fault_q;

  logic [DATA_W-1:0] rhs_mem [MAX_ROWS];
  logic [DATA_W-1:0] piv_mem [MAX_ROWS];
  logic [DATA_W:0]   sol_mem [MAX_ROWS];   // {fault, solution}

  logic [DATA_W-1:0] op_a, op_b;
  logic [DATA_W+FRAC_W-FRAC_W+7:0] prod_sh;
  logic              mul_ovf;
  logic [DATA_W-1:0] mul_sat;
  sat_t              diff_b;
  sat_t              diff_f;
  logic [DATA_W-1:0] div_x;
  logic [DATA_W-1:0] div_q;
  logic              div_flt;
  logic              div_done;
  logic              div_start_ovf;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= SUB_RST;
      main_q <= MAIN_RST;
      sup_q  <= SUPER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUB_DIAG:   sub_q  <= cfg_data_i;
        CFG_MAIN_DIAG:  main_q <= cfg_data_i;
        CFG_SUPER_DIAG: sup_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiplier operand select, product register, floor shift and saturation
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_AC:  begin op_a = sub_q; op_b = sup_q; end
      MUL_AG:  begin op_a = sub_q; op_b = gp_q;  end
      MUL_CS:  begin op_a = sup_q; op_b = sol_q; end
      default: begin op_a = sub_q; op_b = sup_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(op_a) * $signed(op_b);
  end

  assign prod_sh = prod_q[2*DATA_W-1:FRAC_W];
  assign mul_ovf = ~((&prod_sh[2*DATA_W-FRAC_W-1:DATA_W-1]) |
                     ~(|prod_sh[2*DATA_W-FRAC_W-1:DATA_W-1]));
  assign mul_sat = mul_ovf ? (prod_sh[2*DATA_W-FRAC_W-1] ? Q_MIN : Q_MAX)
                           : prod_sh[DATA_W-1:0];

  // Back substitution difference and forward update difference
  assign diff_b = qsub(gp_q, mul_q);
  assign diff_f = qsub(cmd_i.take_t1 ? main_q : f_q, div_q);

  always_comb begin
    unique case (cmd_i.div_src)
      DIV_MUL:  div_x = mul_q;
      DIV_DIFF: div_x = diff_b.val;
      DIV_G:    div_x = gp_q;
      default:  div_x = gp_q;
    endcase
  end
  assign div_start_ovf = cmd_i.div_start && (cmd_i.div_src == DIV_DIFF) && diff_b.ovf;

  tts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_x),
    .divisor_i  (dp_q),
    .done_o     (div_done),
    .quot_o     (div_q),
    .flt_o      (div_flt)
  );

  // Row and work indexes, run fault
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      k_q     <= '0;
      fault_q <= 1'b0;
    end else begin
      if (cmd_i.run_clear) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + 1'b1;
      end

      priority if (cmd_i.in_take) begin
        k_q <= row_q - 1'b1;
      end else if (cmd_i.k_load_row) begin
        k_q <= row_q;
      end else if (cmd_i.k_dec) begin
        k_q <= k_q - 1'b1;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end else if (cmd_i.k_clr) begin
        k_q <= '0;
      end

      if (cmd_i.run_clear) begin
        fault_q <= 1'b0;
      end else begin
        fault_q <= fault_q
                 | (cmd_i.mul_take && mul_ovf)
                 | div_start_ovf
                 | ((cmd_i.take_t1 || cmd_i.take_t2) && (div_flt || diff_f.ovf))
                 | (cmd_i.take_sol && div_flt);
      end
    end
  end

  // Input capture and arithmetic holding registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      f_q    <= in_data_i;
      last_q <= in_last_i;
    end
    if (cmd_i.mul_take) begin
      mul_q <= mul_sat;
    end
    if (cmd_i.take_t1) begin
      piv_new_q <= diff_f.val;
    end
    if (cmd_i.take_t2) begin
      rhs_new_q <= diff_f.val;
    end
    if (cmd_i.take_sol) begin
      sol_q <= div_q;
    end
  end

  // Row stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_fwd) begin
      piv_mem[row_q] <= (row_q == '0) ? main_q : piv_new_q;
      rhs_mem[row_q] <= (row_q == '0) ? f_q : rhs_new_q;
    end
    if (cmd_i.mem_rd) begin
      gp_q <= rhs_mem[k_q];
      dp_q <= piv_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_sol) begin
      sol_mem[k_q] <= {fault_q | div_flt, div_q};
    end
    if (cmd_i.sol_rd) begin
      sol_rd_q <= sol_mem[k_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q  <= sol_rd_q[DATA_W-1:0];
      out_fault_q <= sol_rd_q[DATA_W];
      out_last_q  <= (k_q == row_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_fault_o = out_fault_q;

  assign stat_o.row_zero  = (row_q == '0);
  assign stat_o.row_full  = (row_q == IDX_W'(MAX_ROWS - 1));
  assign stat_o.last      = last_q;
  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.k_top     = (k_q == row_q);
  assign stat_o.div_done  = div_done;
  assign stat_o.out_taken = out_valid_q & out_ready_i;

endmodule

// ----- src/tts_ctrl.sv -----
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer of the solver: forward elimination per row, back substitution
// after the last row or row 63, then delivery of solution rows in index order.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tts_pkg::tts_stat_t stat_i,
  output tts_pkg::tts_cmd_t  cmd_o
);
  import tts_pkg::*;

  state_e  state_q, state_d;
  out_ph_e oph_q, oph_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oph_q   <= OUT_NONE;
    end else begin
      state_q <= state_d;
      oph_q   <= oph_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    oph_d      = oph_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_AC;
    cmd_o.div_src = DIV_G;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        unique case (oph_q)
          OUT_NONE: begin
            in_ready_o = 1'b1;
            if (in_valid_i) begin
              cmd_o.in_take = 1'b1;
              state_d = stat_i.row_zero ? ST_FWR : ST_FRD;
            end
          end
          OUT_RD: begin
            cmd_o.sol_rd = 1'b1;
            oph_d = OUT_LD;
          end
          OUT_LD: begin
            cmd_o.out_load = 1'b1;
            oph_d = OUT_WT;
          end
          OUT_WT: begin
            if (stat_i.out_taken) begin
              if (stat_i.k_top) begin
                cmd_o.run_clear = 1'b1;
                oph_d = OUT_NONE;
              end else begin
                cmd_o.k_inc = 1'b1;
                oph_d = OUT_RD;
              end
            end
          end
          default: oph_d = OUT_NONE;
        endcase
      end
      ST_FRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_FMUL1;
      end
      ST_FMUL1: begin
        cmd_o.mul_sel = MUL_AC;
        state_d = ST_FSAT1;
      end
      ST_FSAT1: begin
        cmd_o.mul_take = 1'b1;
        state_d = ST_FDIV1;
      end
      ST_FDIV1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DIV_MUL;
        state_d = ST_FWT1;
      end
      ST_FWT1: begin
        if (stat_i.div_done) begin
          cmd_o.take_t1 = 1'b1;
          state_d = ST_FMUL2;
        end
      end
      ST_FMUL2: begin
        cmd_o.mul_sel = MUL_AG;
        state_d = ST_FSAT2;
      end
      ST_FSAT2: begin
        cmd_o.mul_take = 1'b1;
        state_d = ST_FDIV2;
      end
      ST_FDIV2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DIV_MUL;
        state_d = ST_FWT2;
      end
      ST_FWT2: begin
        if (stat_i.div_done) begin
          cmd_o.take_t2 = 1'b1;
          state_d = ST_FWR;
        end
      end
      ST_FWR: begin
        cmd_o.wr_fwd = 1'b1;
        if (stat_i.last || stat_i.row_full) begin
          cmd_o.k_load_row = 1'b1;
          state_d = ST_BRD;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_BRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = stat_i.k_top ? ST_BDIV : ST_BMUL;
      end
      ST_BMUL: begin
        cmd_o.mul_sel = MUL_CS;
        state_d = ST_BSAT;
      end
      ST_BSAT: begin
        cmd_o.mul_take = 1'b1;
        state_d = ST_BDIV;
      end
      ST_BDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = stat_i.k_top ? DIV_G : DIV_DIFF;
        state_d = ST_BWT;
      end
      ST_BWT: begin
        if (stat_i.div_done) begin
          cmd_o.take_sol = 1'b1;
          if (stat_i.k_zero) begin
            cmd_o.k_clr = 1'b1;
            oph_d   = OUT_RD;
            state_d = ST_IDLE;
          end else begin
            cmd_o.k_dec = 1'b1;
            state_d = ST_BRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/tridiagonal_thomas_solver.sv -----
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver
// Thomas algorithm solver for a constant-coefficient tridiagonal system in
// signed Q8.24, with forward elimination per row and back substitution.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata            | tlast         | tuser
//  s_axis   | in  | rhs_value[31:0]  | final_row     | -
//  m_axis   | out | solution_value   | run_end       | numeric_fault
//  cfg      | in  | 0 sub, 1 main, 2 super diagonal, data 32 bits
//
//  Row 0 is stored without arithmetic; each later row needs two runs of
//  the shared divider (56 quotient bits each). After the marked row or row
//  63, back substitution runs the divider once per row (the top row skips
//  the multiply), then each solution row is read, loaded and held until taken.
//  Input is not taken during the solve or delivery. No clearing pass.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tts_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tts_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] rhs_value
  input  logic                          s_axis_tlast,   // final_row
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tts_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] solution_value
  output logic                          m_axis_tlast,   // run_end
  output logic                          m_axis_tuser    // [0] numeric_fault
);
  import tts_pkg::*;

  tts_cmd_t  cmd;
  tts_stat_t stat;

  tts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_fault_o (m_axis_tuser)
  );

  // Input and output never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // A marked row starts the solve and closes the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input stays open after the last row");

  // The end of a run returns to accepting rows
  a_end_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("input not reopened after the run end");

endmodule
